>>> rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion, disabled while reset is high
`define VNCF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// shorthand for modules whose clock and reset are named clock and reset
`define VNCF_ASSERT_CR(label, prop, msg) \
   `VNCF_ASSERT(label, clock, reset, prop, msg)

`endif

>>> rtl/vncf_pkg.sv
`timescale 1ns / 1ps
package vncf_pkg;

   localparam int WORLD_HEIGHT = 32;

   localparam int COORD_W   = 21;
   localparam int LOCAL_W   = 6;
   localparam int LVL_W     = 6;
   localparam int BLK_W     = 3;
   localparam int SEED_W    = 64;
   localparam int CSIZE_W   = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE = 1'd1;
   localparam logic [CSIZE_W-1:0]   CHUNK_SIZE_RESET = 7'd16;

   localparam logic [BLK_W-1:0] BLK_AIR     = 3'd0;
   localparam logic [BLK_W-1:0] BLK_BEDROCK = 3'd1;
   localparam logic [BLK_W-1:0] BLK_DIRT    = 3'd2;
   localparam logic [BLK_W-1:0] BLK_GRASS   = 3'd3;
   localparam logic [BLK_W-1:0] BLK_STONE   = 3'd4;

   localparam int NUM_OCT    = 3;
   localparam int NUM_LANES  = 4 * NUM_OCT;
   localparam int TOP_SHIFT  = 6;
   localparam int FRAC_W     = 6;
   localparam int POS_W      = 29;
   localparam int NOISE_W    = 24;
   localparam int R_W        = 30;
   localparam int OCT_W      = 36;
   localparam int WPROD_W    = 52;
   localparam int SUM_W      = 54;
   localparam int NUM_STAGES = 10;

   localparam logic [31:0] MIX1_LO = 32'hed558ccd;
   localparam logic [31:0] MIX1_HI = 32'hff51afd7;
   localparam logic [31:0] MIX2_LO = 32'h1a85ec53;
   localparam logic [31:0] MIX2_HI = 32'hc4ceb9fe;

   localparam logic [15:0] W_OCT0 = 16'd39322;
   localparam logic [15:0] W_OCT1 = 16'd19661;
   localparam logic [15:0] W_OCT2 = 16'd6554;

   localparam logic [WPROD_W:0] ONE_Q52 = {1'b1, {WPROD_W{1'b0}}};

   localparam logic [LVL_W-1:0] TOP_LEVEL   = LVL_W'(WORLD_HEIGHT - 1);
   localparam logic [LVL_W-1:0] HEIGHT_SPAN = LVL_W'(WORLD_HEIGHT - 2);

   typedef struct packed {
      logic [NUM_OCT-1:0][FRAC_W-1:0] fx;
      logic [NUM_OCT-1:0][FRAC_W-1:0] fz;
   } meta_type;

endpackage

>>> rtl/vncf_req_if.sv
`timescale 1ns / 1ps
interface vncf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [vncf_pkg::COORD_W-1:0]  chunk_x;
   logic signed [vncf_pkg::COORD_W-1:0]  chunk_z;
   logic signed [vncf_pkg::COORD_W-1:0]  chunk_y;
   logic        [vncf_pkg::LOCAL_W-1:0]  local_x;
   logic        [vncf_pkg::LOCAL_W-1:0]  local_z;

   modport source (output valid, chunk_x, chunk_z, chunk_y, local_x, local_z, input ready);
   modport sink   (input valid, chunk_x, chunk_z, chunk_y, local_x, local_z, output ready);
endinterface

>>> rtl/vncf_rsp_if.sv
`timescale 1ns / 1ps
interface vncf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [vncf_pkg::LVL_W-1:0]   level;
   logic [vncf_pkg::BLK_W-1:0]   block_id;
   logic [vncf_pkg::LVL_W-1:0]   column_height;
   logic                         last;

   modport source (output valid, level, block_id, column_height, last, input ready);
   modport sink   (input valid, level, block_id, column_height, last, output ready);
endinterface

>>> rtl/value_noise_column_fill.sv
`timescale 1ns / 1ps
// Value-noise terrain column generator. Each request names a column (chunk x/y/z and local
// x/z); the block answers with WORLD_HEIGHT responses, one block id per level from level 0
// upward, with the column surface height on each and last set on the top level. The height
// comes out of a ten-stage pipeline (position multiply, hash keys, two murmur multiply
// stages split into 32-bit partial products, final xorshift, bilinear mix in two stages,
// octave weighting, sum and clamp, height scale). A request enters the pipeline every cycle
// when free, but the response side emits one level per cycle while rsp ready is high, so a
// column holds the output for WORLD_HEIGHT (32) levels; further requests fill the pipeline
// until it stalls, and back-to-back columns are emitted with no gap. The user must write seed
// and chunk size through the csr port only while the block is idle; this is not enforced.
`include "assert_macros.svh"
module value_noise_column_fill (
   input  logic                              clock,
   input  logic                              reset,
   vncf_req_if.sink                          req_ch,
   vncf_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [vncf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vncf_pkg::SEED_W-1:0]       csr_wdata
);
   import vncf_pkg::*;

   // configuration
   logic [SEED_W-1:0]  seed_ff;
   logic [CSIZE_W-1:0] csize_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         csize_ff <= CHUNK_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEED:       seed_ff  <= csr_wdata;
            CSR_CHUNK_SIZE: csize_ff <= csr_wdata[CSIZE_W-1:0];
            default:        ;
         endcase
      end
   end

   // pipeline control
   logic [NUM_STAGES:1] vld_ff, vld_in;
   logic [NUM_STAGES:1] yz_ff, yz_in;
   logic adv, can_load, take, in_fire;

   // emitter state
   logic             busy_ff, busy_in;
   logic [LVL_W-1:0] cnt_ff, cnt_in;
   logic [LVL_W-1:0] hgt_ff, hgt_in;
   logic             lay_ff, lay_in;

   assign can_load = !busy_ff || (rsp_ch.ready && cnt_ff == TOP_LEVEL);
   assign take     = vld_ff[NUM_STAGES] && can_load;
   assign adv      = !vld_ff[NUM_STAGES] || can_load;
   assign in_fire  = req_ch.valid && adv;
   assign req_ch.ready = adv;

   assign vld_in = {vld_ff[NUM_STAGES-1:1], in_fire};
   assign yz_in  = {yz_ff[NUM_STAGES-1:1], (req_ch.chunk_y == '0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         yz_ff <= yz_in;
      end
   end

   // stage 1: world position
   logic signed [POS_W-1:0] x_ff, x_in, z_ff, z_in;

   always_comb begin
      x_in = POS_W'($signed(req_ch.chunk_x) * $signed({1'b0, csize_ff}))
             + $signed({{(POS_W-LOCAL_W){1'b0}}, req_ch.local_x});
      z_in = POS_W'($signed(req_ch.chunk_z) * $signed({1'b0, csize_ff}))
             + $signed({{(POS_W-LOCAL_W){1'b0}}, req_ch.local_z});
   end

   // stage 2: cell keys; lane = octave*4 + corner, corner bit0 = +x, bit1 = +z
   logic [NUM_LANES-1:0][63:0] key_ff, key_in;
   meta_type m2_ff, m2_in;

   always_comb begin
      logic signed [POS_W-1:0] xi, zi, xa, za;
      int k;
      for (int o = 0; o < NUM_OCT; o++) begin
         k = TOP_SHIFT - o;
         xi = x_ff >>> k;
         zi = z_ff >>> k;
         m2_in.fx[o] = x_ff[FRAC_W-1:0] & FRAC_W'((1 << k) - 1);
         m2_in.fz[o] = z_ff[FRAC_W-1:0] & FRAC_W'((1 << k) - 1);
         for (int c = 0; c < 4; c++) begin
            xa = xi + POS_W'(c % 2);
            za = zi + POS_W'(c / 2);
            key_in[o*4+c] = {{(32-POS_W){xa[POS_W-1]}}, xa, 32'd0}
                            ^ {{(64-POS_W){za[POS_W-1]}}, za} ^ seed_ff;
         end
      end
   end

   // stage 3: first mix multiply, partial products
   logic [NUM_LANES-1:0][63:0] pll_ff, pll_in;
   logic [NUM_LANES-1:0][31:0] pmid_ff, pmid_in;
   meta_type m3_ff;

   always_comb begin
      logic [63:0] h;
      for (int i = 0; i < NUM_LANES; i++) begin
         h = key_ff[i] ^ (key_ff[i] >> 33);
         pll_in[i]  = {32'd0, h[31:0]} * {32'd0, MIX1_LO};
         pmid_in[i] = h[31:0] * MIX1_HI + h[63:32] * MIX1_LO;
      end
   end

   // stage 4: second mix multiply, partial products
   logic [NUM_LANES-1:0][63:0] qll_ff, qll_in;
   logic [NUM_LANES-1:0][31:0] qmid_ff, qmid_in;
   meta_type m4_ff;

   always_comb begin
      logic [63:0] h;
      for (int i = 0; i < NUM_LANES; i++) begin
         h = pll_ff[i] + {pmid_ff[i], 32'd0};
         h = h ^ (h >> 33);
         qll_in[i]  = {32'd0, h[31:0]} * {32'd0, MIX2_LO};
         qmid_in[i] = h[31:0] * MIX2_HI + h[63:32] * MIX2_LO;
      end
   end

   // stage 5: final xorshift, 24-bit noise values
   logic [NUM_LANES-1:0][NOISE_W-1:0] n_ff, n_in;
   meta_type m5_ff;

   always_comb begin
      logic [63:0] h;
      for (int i = 0; i < NUM_LANES; i++) begin
         h = qll_ff[i] + {qmid_ff[i], 32'd0};
         h = h ^ (h >> 33);
         n_in[i] = h[NOISE_W-1:0];
      end
   end

   // stage 6: mix along x
   logic [NUM_OCT-1:0][R_W-1:0] r0_ff, r0_in, r1_ff, r1_in;
   meta_type m6_ff;

   always_comb begin
      logic [FRAC_W:0] w0, w1;
      for (int o = 0; o < NUM_OCT; o++) begin
         w1 = {1'b0, m5_ff.fx[o]};
         w0 = (FRAC_W+1)'(1 << (TOP_SHIFT - o)) - w1;
         r0_in[o] = {{(R_W-NOISE_W){1'b0}}, n_ff[o*4+0]} * {{(R_W-FRAC_W-1){1'b0}}, w0}
                  + {{(R_W-NOISE_W){1'b0}}, n_ff[o*4+1]} * {{(R_W-FRAC_W-1){1'b0}}, w1};
         r1_in[o] = {{(R_W-NOISE_W){1'b0}}, n_ff[o*4+2]} * {{(R_W-FRAC_W-1){1'b0}}, w0}
                  + {{(R_W-NOISE_W){1'b0}}, n_ff[o*4+3]} * {{(R_W-FRAC_W-1){1'b0}}, w1};
      end
   end

   // stage 7: mix along z
   logic [NUM_OCT-1:0][OCT_W-1:0] oct_ff, oct_in;

   always_comb begin
      logic [FRAC_W:0] w0, w1;
      for (int o = 0; o < NUM_OCT; o++) begin
         w1 = {1'b0, m6_ff.fz[o]};
         w0 = (FRAC_W+1)'(1 << (TOP_SHIFT - o)) - w1;
         oct_in[o] = {{(OCT_W-R_W){1'b0}}, r0_ff[o]} * {{(OCT_W-FRAC_W-1){1'b0}}, w0}
                   + {{(OCT_W-R_W){1'b0}}, r1_ff[o]} * {{(OCT_W-FRAC_W-1){1'b0}}, w1};
      end
   end

   // stage 8: octave weights, all brought to q0.52
   logic [NUM_OCT-1:0][WPROD_W-1:0] wp_ff, wp_in;

   always_comb begin
      logic [OCT_W-1:0] v1, v2;
      v1 = oct_ff[1] << 2;
      v2 = oct_ff[2] << 4;
      wp_in[0] = {16'd0, oct_ff[0]} * {{(WPROD_W-16){1'b0}}, W_OCT0};
      wp_in[1] = {16'd0, v1} * {{(WPROD_W-16){1'b0}}, W_OCT1};
      wp_in[2] = {16'd0, v2} * {{(WPROD_W-16){1'b0}}, W_OCT2};
   end

   // stage 9: sum and clamp to one
   logic [WPROD_W:0] sum_ff, sum_in;

   always_comb begin
      logic [SUM_W-1:0] s;
      s = SUM_W'(wp_ff[0]) + SUM_W'(wp_ff[1]) + SUM_W'(wp_ff[2]);
      if (s > SUM_W'(ONE_Q52)) begin
         sum_in = ONE_Q52;
      end else begin
         sum_in = s[WPROD_W:0];
      end
   end

   // stage 10: surface height
   logic [LVL_W-1:0] height_ff, height_in;

   always_comb begin
      logic [WPROD_W+LVL_W:0] p;
      p = {{LVL_W{1'b0}}, sum_ff} * {{(WPROD_W+1){1'b0}}, HEIGHT_SPAN};
      height_in = p[WPROD_W+LVL_W-1:WPROD_W] + LVL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff      <= x_in;
         z_ff      <= z_in;
         key_ff    <= key_in;
         m2_ff     <= m2_in;
         pll_ff    <= pll_in;
         pmid_ff   <= pmid_in;
         m3_ff     <= m2_ff;
         qll_ff    <= qll_in;
         qmid_ff   <= qmid_in;
         m4_ff     <= m3_ff;
         n_ff      <= n_in;
         m5_ff     <= m4_ff;
         r0_ff     <= r0_in;
         r1_ff     <= r1_in;
         m6_ff     <= m5_ff;
         oct_ff    <= oct_in;
         wp_ff     <= wp_in;
         sum_ff    <= sum_in;
         height_ff <= height_in;
      end
   end

   // level emitter
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      hgt_in  = hgt_ff;
      lay_in  = lay_ff;
      if (take) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         hgt_in  = height_ff;
         lay_in  = yz_ff[NUM_STAGES];
      end else if (busy_ff && rsp_ch.ready) begin
         if (cnt_ff == TOP_LEVEL) begin
            busy_in = 1'b0;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + LVL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         hgt_ff  <= '0;
         lay_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         hgt_ff  <= hgt_in;
         lay_ff  <= lay_in;
      end
   end

   always_comb begin
      logic [LVL_W:0] lv3;
      lv3 = {1'b0, cnt_ff} + (LVL_W+1)'(3);
      rsp_ch.block_id = BLK_AIR;
      if (lay_ff) begin
         if (cnt_ff == '0) begin
            rsp_ch.block_id = BLK_BEDROCK;
         end else if (cnt_ff > hgt_ff) begin
            rsp_ch.block_id = BLK_AIR;
         end else if (lv3 < {1'b0, hgt_ff}) begin
            rsp_ch.block_id = BLK_STONE;
         end else if (cnt_ff < hgt_ff) begin
            rsp_ch.block_id = BLK_DIRT;
         end else begin
            rsp_ch.block_id = BLK_GRASS;
         end
      end
   end

   assign rsp_ch.valid         = busy_ff;
   assign rsp_ch.level         = cnt_ff;
   assign rsp_ch.column_height = hgt_ff;
   assign rsp_ch.last          = (cnt_ff == TOP_LEVEL);

   `VNCF_ASSERT_CR(a_level_steps, (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=> (rsp_ch.valid && rsp_ch.level == $past(rsp_ch.level) + 1'b1), "level did not advance by one")
   `VNCF_ASSERT_CR(a_height_range, rsp_ch.valid |-> (rsp_ch.column_height != '0 && rsp_ch.column_height <= TOP_LEVEL), "column height out of range")
   `VNCF_ASSERT_CR(a_load_moves, (vld_ff[NUM_STAGES] && !busy_ff) |=> (busy_ff && rsp_ch.level == '0), "finished column not loaded into emitter")

endmodule
